// ===== rtl/core/tcsm_pkg.sv =====
// Package for the task CPU share monitor: sizes, widths and sequencer states.
// No dependencies.
`default_nettype none
package tcsm_pkg;
	localparam int MaxTasks = 16;
	localparam int IdxW = $clog2(MaxTasks);
	localparam int CntW = $clog2(MaxTasks + 1);
	localparam int SumW = 32 + CntW;
	localparam int NumW = SumW + 1;
	localparam int QuoW = 8;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOOK = 6'b000010,
		ST_DELT = 6'b000100,
		ST_DIVI = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_COPY = 6'b100000
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/task_cpu_share_monitor_top.sv =====
// Top level of the task CPU share monitor.
// Depends on tcsm_pkg.
//
// Input words (s_axis) carry one task record each; tlast marks the final
// record of a snapshot. Non-final records are stored as they are taken,
// while the table has room. On the final record the block is busy: for
// each task it searches the previous table one entry per cycle and then
// forms the delta in the ST_DELT state. Then for each result it seeds a
// restoring divider, runs it one quotient bit per cycle, and holds the
// result word on m_axis until taken. At the end the new table is copied
// into the old one, one entry per cycle.
// All tasks share the one search compare and the one divider. The next
// snapshot is accepted only after the copy is done.
// Oversized snapshots are dropped without results.
// Reset clears the sequencer state, the fill and index counters, the
// overflow flag, the previous-snapshot state, the sum and the output
// valid; tables are undefined until written.
// A stalled receiver simply holds the block in the emit state.
`default_nettype none
module task_cpu_share_monitor_top import tcsm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// task_id[15:0], run_count[47:16], stack_free[63:48], total_run[95:64]
	input  wire  [95:0] s_axis_tdata,
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// slot[3:0], cpu_percent[10:4], stack_free_out[26:11], window_ticks[58:27]
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	logic [15:0] new_ids_q [MaxTasks];
	logic [31:0] new_counts_q [MaxTasks];
	logic [15:0] headrooms_q [MaxTasks];
	logic [31:0] deltas_q [MaxTasks];
	logic [15:0] old_ids_q [MaxTasks];
	logic [31:0] old_counts_q [MaxTasks];

	state_t state_q;
	logic [CntW-1:0] fill_q, old_n_q, k_q, j_q;
	logic [31:0] old_total_q, window_q, total_q;
	logic have_old_q, ovf_q;
	logic [SumW-1:0] sum_q;
	logic found_q;
	logic [31:0] match_q;
	logic [NumW-1:0] rem_q;
	logic [QuoW-1:0] quo_q;
	logic [3:0] bit_q;
	logic [63:0] out_q;
	logic out_last_q, out_v_q;

	wire [15:0] in_id = s_axis_tdata[15:0];
	wire [31:0] in_cnt = s_axis_tdata[47:16];
	wire [15:0] in_hr = s_axis_tdata[63:48];
	wire [31:0] in_tot = s_axis_tdata[95:64];
	wire acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	wire [IdxW-1:0] k_i = k_q[IdxW-1:0];
	wire [IdxW-1:0] j_i = j_q[IdxW-1:0];
	wire full = (fill_q == CntW'(MaxTasks));
	wire [CntW-1:0] n_now = full ? fill_q : fill_q + 1'b1;

	// Delta with lookup result; a delta beyond a nonzero window is zeroed.
	logic [31:0] dlt;
	always_comb begin
		dlt = new_counts_q[k_i];
		if (have_old_q && found_q) dlt = dlt - match_q;
		if (window_q != 32'd0 && dlt > window_q) dlt = 32'd0;
	end

	// Share of the current task, saturated, and zero for a zero sum.
	logic [6:0] pct_now;
	always_comb begin
		if (sum_q == '0)
			pct_now = 7'd0;
		else if (quo_q > 8'd100 || rem_q >= NumW'(sum_q))
			pct_now = 7'd100;
		else
			pct_now = quo_q[6:0];
	end

	// Divider trial subtraction: numerator bits shift in from the top.
	wire [NumW-1:0] trial = {rem_q[NumW-2:0], quo_q[QuoW-1]};
	wire [NumW:0] diff = {1'b0, trial} - {2'b0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			old_n_q <= '0;
			old_total_q <= '0;
			have_old_q <= 1'b0;
			ovf_q <= 1'b0;
			sum_q <= '0;
			out_v_q <= 1'b0;
			k_q <= '0;
			j_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					if (s_axis_tlast) begin
						if (full || ovf_q) begin
							fill_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							fill_q <= n_now;
							total_q <= in_tot;
							window_q <= have_old_q ? in_tot - old_total_q : in_tot;
							sum_q <= '0;
							k_q <= '0;
							j_q <= '0;
							found_q <= 1'b0;
							state_q <= ST_LOOK;
						end
					end else if (full) begin
						ovf_q <= 1'b1;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_LOOK: begin
					if (j_q == old_n_q) begin
						state_q <= ST_DELT;
					end else if (old_ids_q[j_i] == new_ids_q[k_i]) begin
						found_q <= 1'b1;
						match_q <= old_counts_q[j_i];
						state_q <= ST_DELT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DELT: begin
					deltas_q[k_i] <= dlt;
					sum_q <= sum_q + SumW'(dlt);
					j_q <= '0;
					found_q <= 1'b0;
					if (k_q + 1'b1 == fill_q) begin
						k_q <= '0;
						state_q <= ST_DIVI;
						bit_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_DIVI: begin
					if (bit_q == 4'd0) begin
						// Numerator d*100 + sum/2; its low QuoW bits seed the quotient
						// register and shift in; remainder seeded as numerator >> QuoW.
						rem_q <= NumW'((({7'd0, deltas_q[k_i]} * 39'd100
							+ 39'(sum_q >> 1)) >> QuoW));
						quo_q <= QuoW'((39'(deltas_q[k_i]) * 39'd100
							+ 39'(sum_q >> 1)));
						bit_q <= 4'd1;
					end else begin
						if (!diff[NumW] ) begin
							rem_q <= diff[NumW-1:0];
							quo_q <= {quo_q[QuoW-2:0], 1'b1};
						end else begin
							rem_q <= trial;
							quo_q <= {quo_q[QuoW-2:0], 1'b0};
						end
						if (bit_q == 4'(QuoW)) state_q <= ST_EMIT;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						out_q <= {5'd0, window_q, headrooms_q[k_i], pct_now, k_q[3:0]};
						out_last_q <= (k_q + 1'b1 == fill_q);
					end else if (m_axis_tready) begin
						out_v_q <= 1'b0;
						if (k_q + 1'b1 == fill_q) begin
							k_q <= '0;
							state_q <= ST_COPY;
						end else begin
							k_q <= k_q + 1'b1;
							bit_q <= '0;
							state_q <= ST_DIVI;
						end
					end
				end
				ST_COPY: begin
					old_ids_q[k_i] <= new_ids_q[k_i];
					old_counts_q[k_i] <= new_counts_q[k_i];
					if (k_q + 1'b1 == fill_q) begin
						old_n_q <= fill_q;
						old_total_q <= total_q;
						have_old_q <= 1'b1;
						fill_q <= '0;
						k_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !full) begin
			new_ids_q[fill_q[IdxW-1:0]] <= in_id;
			new_counts_q[fill_q[IdxW-1:0]] <= in_cnt;
			headrooms_q[fill_q[IdxW-1:0]] <= in_hr;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;
	assign m_axis_tlast = out_last_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken while emitting");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:4] <= 7'd100) else $error("share above 100");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(MaxTasks)) else $error("fill count out of range");
endmodule
`default_nettype wire

// ===== tb/sv/tb_task_cpu_share_monitor_top.sv =====
// Testbench for the task CPU share monitor: drives snapshots of task records
// and checks every share word against an in-bench predictor of the block.
// Depends on tcsm_pkg and task_cpu_share_monitor_top.
`default_nettype none
module tb_task_cpu_share_monitor_top import tcsm_pkg::*;;

	typedef struct packed {
		logic [3:0]  slot;
		logic [6:0]  cpu_percent;
		logic [15:0] stack_free_out;
		logic [31:0] window_ticks;
		logic        last_out;
	} share_t;

	// Predicts the share words of each snapshot and holds them until they come out.
	class share_board;
		logic [15:0] prev_ids[MaxTasks];
		logic [31:0] prev_counts[MaxTasks];
		int unsigned prev_n;
		logic [31:0] prev_total;
		bit          have_prev;
		logic [15:0] cur_ids[MaxTasks];
		logic [31:0] cur_counts[MaxTasks];
		logic [15:0] cur_room[MaxTasks];
		int unsigned fill;
		bit          too_many;
		share_t      pending[$];
		int          errors;

		function new();
			prev_n = 0;
			prev_total = '0;
			have_prev = 0;
			fill = 0;
			too_many = 0;
			errors = 0;
		endfunction

		function void note_record(logic [15:0] id, logic [31:0] cnt, logic [15:0] room,
				logic [31:0] total, bit lst);
			logic [31:0] window;
			logic [31:0] d[MaxTasks];
			logic [63:0] sum;
			logic [63:0] pct;
			share_t w;
			int p;
			if (fill < MaxTasks) begin
				cur_ids[fill] = id;
				cur_counts[fill] = cnt;
				cur_room[fill] = room;
				fill++;
			end else begin
				too_many = 1;
			end
			if (!lst)
				return;
			if (too_many) begin
				fill = 0;
				too_many = 0;
				return;
			end
			window = have_prev ? total - prev_total : total;
			sum = 0;
			for (int k = 0; k < fill; k++) begin
				d[k] = cur_counts[k];
				p = -1;
				for (int j = 0; j < prev_n; j++)
					if (p < 0 && prev_ids[j] == cur_ids[k])
						p = j;
				if (have_prev && p >= 0)
					d[k] = d[k] - prev_counts[p];
				if (window != 0 && d[k] > window)
					d[k] = 0;
				sum += d[k];
			end
			for (int k = 0; k < fill; k++) begin
				pct = 0;
				if (sum != 0)
					pct = ({32'd0, d[k]} * 100 + sum / 2) / sum;
				if (pct > 100)
					pct = 100;
				w.slot = k[3:0];
				w.cpu_percent = pct[6:0];
				w.stack_free_out = cur_room[k];
				w.window_ticks = window;
				w.last_out = (k + 1 == fill);
				pending.push_back(w);
				prev_ids[k] = cur_ids[k];
				prev_counts[k] = cur_counts[k];
			end
			prev_n = fill;
			prev_total = total;
			have_prev = 1;
			fill = 0;
		endfunction

		function void check_share(share_t got);
			share_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.slot != exp.slot) begin
				$error("slot: expected %0d, got %0d", exp.slot, got.slot);
				errors++;
			end
			if (got.cpu_percent != exp.cpu_percent) begin
				$error("cpu_percent: expected %0d, got %0d", exp.cpu_percent, got.cpu_percent);
				errors++;
			end
			if (got.stack_free_out != exp.stack_free_out) begin
				$error("stack_free_out: expected %0h, got %0h", exp.stack_free_out,
					got.stack_free_out);
				errors++;
			end
			if (got.window_ticks != exp.window_ticks) begin
				$error("window_ticks: expected %0h, got %0h", exp.window_ticks, got.window_ticks);
				errors++;
			end
			if (got.last_out != exp.last_out) begin
				$error("last_out: expected %0d, got %0d", exp.last_out, got.last_out);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;

	share_board board;
	bit          hold_rx;
	bit          rx_random;
	int unsigned records_sent;
	logic [15:0] id_pool[16];
	logic [31:0] cnt_pool[16];
	logic [31:0] run_clock;

	task_cpu_share_monitor_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Sends one record word, after a random gap unless no_gap is set, and waits for its acceptance.
	task automatic send_record(logic [15:0] id, logic [31:0] cnt, logic [15:0] room,
			logic [31:0] total, bit lst, bit no_gap);
		int gap;
		gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {total, room, cnt, id};
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_record(id, cnt, room, total, lst);
		records_sent++;
	endtask

	// One snapshot of n tasks; ids mostly come from a small pool so that many match.
	task automatic send_snapshot(int n, bit burst);
		logic [15:0] id;
		logic [31:0] cnt;
		int s;
		run_clock += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000);
		for (int k = 0; k < n; k++) begin
			s = $urandom_range(0, 15);
			id = $urandom_range(0, 7) == 0 ? 16'($urandom) : id_pool[s];
			case ($urandom_range(0, 5))
				0: cnt = $urandom;
				1: cnt = cnt_pool[s] - $urandom_range(0, 10);
				default: cnt = cnt_pool[s] + $urandom_range(0, 800);
			endcase
			cnt_pool[s] = cnt;
			send_record(id, cnt, 16'($urandom), $urandom_range(0, 9) == 0 ? $urandom : run_clock,
				k == n - 1, burst);
		end
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0)
			@(posedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (400) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_share(share_t'({m_axis_tdata[3:0], m_axis_tdata[10:4],
				m_axis_tdata[26:11], m_axis_tdata[58:27], m_axis_tlast}));
	end

	// Receiver: random stalls per word when rx_random is set, or a long hold-off when asked.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_rx = 0;
			end
			stall = rx_random ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready))
				@(posedge clk);
		end
	end

	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		board = new();
		hold_rx = 0;
		rx_random = 1;
		records_sent = 0;
		run_clock = 0;
		for (int k = 0; k < 16; k++) begin
			id_pool[k] = 16'($urandom);
			cnt_pool[k] = $urandom;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lone task with no previous snapshot, then zero sum and zero window.
		send_record(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0);
		send_record(16'h0000, 32'h0, 16'h0, 32'h0, 0, 0);
		send_record(16'hFFFF, 32'hFFFF_FFFF, 16'h1234, 32'hFFFF_FFFF, 1, 0);
		// Duplicate ids: the first old match wins; a delta beyond the window is zeroed.
		send_record(16'h0007, 32'd100, 16'h5555, 32'd10, 0, 0);
		send_record(16'h0007, 32'd900, 16'hAAAA, 32'd10, 1, 0);
		send_record(16'h0007, 32'd150, 16'h0001, 32'd1000, 0, 0);
		send_record(16'h0009, 32'd5000, 16'h0002, 32'd1000, 1, 0);
		// Wrapped counter delta.
		send_record(16'h0007, 32'd50, 16'h8000, 32'd1000, 1, 0);
		// Oversized snapshot is dropped; then a full one of MaxTasks.
		for (int k = 0; k <= MaxTasks; k++)
			send_record(16'(k), 32'(k * 3), 16'(k), 32'd2000, k == MaxTasks, 0);
		for (int k = 0; k < MaxTasks; k++)
			send_record(16'(k), 32'(k * 7 + 1), 16'(~k), 32'd2200, k == MaxTasks - 1, 0);
		wait_drained();

		// Receiver holds off while snapshots keep coming.
		hold_rx = 1;
		send_snapshot(16, 1);
		send_snapshot(3, 1);
		wait_drained();

		while (records_sent < 260) begin
			case ($urandom_range(0, 9))
				0: send_snapshot(MaxTasks + 1 + $urandom_range(0, 3), 0);
				1: send_snapshot(MaxTasks, 0);
				2: begin
					rx_random = ~rx_random;
					send_snapshot($urandom_range(1, 6), $urandom_range(0, 1));
				end
				default: send_snapshot($urandom_range(1, 6), 0);
			endcase
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
